@@ src/c2c_pkg.sv @@
// shared types and codes for the coordinate to csr converter
package c2c_pkg;

    localparam int ROW_W    = 10;
    localparam int COL_W    = 16;
    localparam int VAL_W    = 64;
    localparam int KEY_W    = ROW_W + COL_W;
    localparam int REG_W    = 11;
    localparam int CFG_IDX_W = 8;
    localparam int FLD_W    = 11;

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_FINISH = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ROW_OOR  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_NOTHING  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECLARED  = 8'd1;

    typedef struct packed {
        logic [1:0]       action;
        logic [ROW_W-1:0] entry_row;
        logic [COL_W-1:0] entry_column;
        logic [VAL_W-1:0] entry_value;
    } t_cmd;

    typedef struct packed {
        logic [1:0]       status;
        logic             kind;
        logic [FLD_W-1:0] position;
        logic [FLD_W-1:0] offset;
        logic [COL_W-1:0] column;
        logic [VAL_W-1:0] value;
        logic             last;
    } t_result;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        logic [VAL_W-1:0] value;
    } t_entry;

    typedef struct packed {
        logic cand;
        logic take;
        logic drop;
    } t_key_flags;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_OFF_WAIT,
        S_OFF_CMP,
        S_RD_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_LOADING,
        PH_READING,
        PH_DRAINED
    } t_phase;

endpackage

@@ src/c2c_ram.sv @@
// generic single write, single registered read ram
module c2c_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/c2c_key_unit.sv @@
// shared key compare unit for the selection scan
module c2c_key_unit import c2c_pkg::*; #(
    parameter int RW = 11
) (
    input  t_entry           i_entry,
    input  logic [KEY_W-1:0] i_prev_key,
    input  logic [KEY_W-1:0] i_best_key,
    input  logic             i_first,
    input  logic             i_have,
    input  logic [RW-1:0]    i_rows,
    output t_key_flags       o_flags
);

    logic [KEY_W-1:0] key;
    logic             in_range;

    always_comb begin
        key           = {i_entry.row, i_entry.column};
        in_range      = 32'(i_entry.row) < 32'(i_rows);
        o_flags.drop  = !in_range;
        o_flags.cand  = in_range && (i_first || key > i_prev_key);
        o_flags.take  = o_flags.cand && (!i_have || key <= i_best_key);
    end

endmodule

@@ src/coordinate_to_csr_converter_unit.sv @@
// top level of the coordinate to csr converter
//
// Commands are taken when i_start is high and o_busy is low; every command
// gives exactly one result, shown for one cycle with o_done, and the
// receiver cannot hold it off. A load or an invalid command answers in the
// next cycle and never raises busy. A read goes through S_RD_OUT because the
// offset table and the entry store have a registered read port. A finish
// runs a selection scan over the n loaded entries through one key compare
// unit and one ram read port: (m + 1) passes for m merged entries, then a
// row offset sweep; the result follows in the cycle after the sweep ends.
// The stores need no clearing pass after reset.
module coordinate_to_csr_converter_unit import c2c_pkg::*; #(
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_ENTRIES = 1024,
    parameter int COLUMN_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  t_cmd                 i_cmd,
    output logic                 o_done,
    output t_result              o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]     i_cfg_data
);

    localparam int IW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int EDEPTH = 2 * (2 ** IW);
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int RW  = $clog2(MAX_ROWS + 1);
    localparam int ODEPTH = MAX_ROWS + 1;
    localparam int OAW = $clog2(ODEPTH);
    localparam int PW  = $clog2(MAX_ROWS + MAX_ENTRIES + 2);
    localparam logic [COL_W-1:0] COL_MASK = (COLUMN_BITS >= COL_W) ? {COL_W{1'b1}} :
        COL_W'((64'd1 << COLUMN_BITS) - 64'd1);

    t_state           r_state, n_state;
    t_phase           r_phase, n_phase;
    logic             r_src, n_src;
    logic [CW-1:0]    r_loaded, n_loaded;
    logic [CW-1:0]    r_merged, n_merged;
    logic [CW-1:0]    r_m, n_m;
    logic [CW-1:0]    r_i, n_i;
    logic             r_dv, n_dv;
    logic             r_first, n_first;
    logic             r_have, n_have;
    logic             r_drop, n_drop;
    t_entry           r_best, n_best;
    logic [KEY_W-1:0] r_prev_key, n_prev_key;
    logic [CW-1:0]    r_q, n_q;
    logic [RW-1:0]    r_oi, n_oi;
    logic [RW-1:0]    r_lat_rows, n_lat_rows;
    logic [CW-1:0]    r_lat_slots, n_lat_slots;
    logic [PW-1:0]    r_rdptr, n_rdptr;
    logic [REG_W-1:0] r_row_count;
    logic [REG_W-1:0] r_declared;
    logic             r_done, n_done;
    t_result          r_res, n_res;

    logic             e_we;
    logic [IW:0]      e_waddr, e_raddr;
    t_entry           e_wdata, e_rdata;
    logic             o_we;
    logic [OAW-1:0]   o_waddr, o_raddr;
    logic [CW-1:0]    o_wdata, o_rdata;

    logic [RW-1:0]    rows_now;
    logic [CW-1:0]    slots_now;
    t_key_flags       flags;

    c2c_ram #(.WIDTH($bits(t_entry)), .DEPTH(EDEPTH)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    c2c_ram #(.WIDTH(CW), .DEPTH(ODEPTH)) u_offset_ram (
        .i_clk   (i_clk),
        .i_we    (o_we),
        .i_waddr (o_waddr),
        .i_wdata (o_wdata),
        .i_raddr (o_raddr),
        .o_rdata (o_rdata)
    );

    c2c_key_unit #(.RW(RW)) u_key_unit (
        .i_entry    (e_rdata),
        .i_prev_key (r_prev_key),
        .i_best_key ({r_best.row, r_best.column}),
        .i_first    (r_first),
        .i_have     (r_have),
        .i_rows     (rows_now),
        .o_flags    (flags)
    );

    always_comb begin
        if (r_row_count == '0) begin
            rows_now = RW'(1);
        end else if (32'(r_row_count) > 32'(MAX_ROWS)) begin
            rows_now = RW'(MAX_ROWS);
        end else begin
            rows_now = RW'(r_row_count);
        end
        if (32'(r_declared) > 32'(MAX_ENTRIES)) begin
            slots_now = CW'(MAX_ENTRIES);
        end else begin
            slots_now = CW'(r_declared);
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_busy      = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_result    = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= REG_W'(1);
            r_declared  <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_ROW_COUNT) begin
                r_row_count <= i_cfg_data;
            end else if (i_cfg_index == CFG_DECLARED) begin
                r_declared <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_LOADING;
            r_src       <= 1'b0;
            r_loaded    <= '0;
            r_merged    <= '0;
            r_m         <= '0;
            r_i         <= '0;
            r_dv        <= 1'b0;
            r_first     <= 1'b1;
            r_have      <= 1'b0;
            r_drop      <= 1'b0;
            r_q         <= '0;
            r_oi        <= '0;
            r_lat_rows  <= RW'(1);
            r_lat_slots <= '0;
            r_rdptr     <= '0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_src       <= n_src;
            r_loaded    <= n_loaded;
            r_merged    <= n_merged;
            r_m         <= n_m;
            r_i         <= n_i;
            r_dv        <= n_dv;
            r_first     <= n_first;
            r_have      <= n_have;
            r_drop      <= n_drop;
            r_q         <= n_q;
            r_oi        <= n_oi;
            r_lat_rows  <= n_lat_rows;
            r_lat_slots <= n_lat_slots;
            r_rdptr     <= n_rdptr;
            r_done      <= n_done;
        end
        r_best     <= n_best;
        r_prev_key <= n_prev_key;
        r_res      <= n_res;
    end

    always_comb begin
        logic [CW-1:0] cnt;
        logic [PW-1:0] e_full;
        logic          p_le_r;

        n_state     = r_state;
        n_phase     = r_phase;
        n_src       = r_src;
        n_loaded    = r_loaded;
        n_merged    = r_merged;
        n_m         = r_m;
        n_i         = r_i;
        n_dv        = r_dv;
        n_first     = r_first;
        n_have      = r_have;
        n_drop      = r_drop;
        n_best      = r_best;
        n_prev_key  = r_prev_key;
        n_q         = r_q;
        n_oi        = r_oi;
        n_lat_rows  = r_lat_rows;
        n_lat_slots = r_lat_slots;
        n_rdptr     = r_rdptr;
        n_done      = 1'b0;
        n_res       = r_res;

        cnt    = (r_phase != PH_LOADING) ? '0 : r_loaded;
        e_full = r_rdptr - PW'(r_lat_rows) - PW'(1);
        p_le_r = r_rdptr <= PW'(r_lat_rows);

        e_we    = 1'b0;
        e_waddr = {r_src, cnt[IW-1:0]};
        e_wdata = r_best;
        e_raddr = {r_src, e_full[IW-1:0]};
        o_we    = 1'b0;
        o_waddr = r_oi[OAW-1:0];
        o_wdata = r_q;
        o_raddr = r_rdptr[OAW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_cmd.action)
                        ACT_LOAD: begin
                            n_res    = '0;
                            n_done   = 1'b1;
                            n_phase  = PH_LOADING;
                            n_loaded = cnt;
                            if (r_phase != PH_LOADING) begin
                                n_merged = '0;
                                n_rdptr  = '0;
                            end
                            if (32'(i_cmd.entry_row) >= 32'(rows_now)) begin
                                n_res.status = ST_ROW_OOR;
                            end else if (32'(cnt) >= 32'(MAX_ENTRIES)) begin
                                n_res.status = ST_OVERFLOW;
                            end else begin
                                e_we           = 1'b1;
                                e_wdata.row    = i_cmd.entry_row;
                                e_wdata.column = i_cmd.entry_column & COL_MASK;
                                e_wdata.value  = i_cmd.entry_value;
                                n_loaded       = cnt + CW'(1);
                            end
                        end
                        ACT_FINISH: begin
                            n_state = S_SCAN;
                            n_i     = '0;
                            n_dv    = 1'b0;
                            n_first = 1'b1;
                            n_have  = 1'b0;
                            n_m     = '0;
                            n_drop  = 1'b0;
                        end
                        ACT_READ: begin
                            if (r_phase == PH_READING) begin
                                n_state = S_RD_OUT;
                            end else begin
                                n_res        = '0;
                                n_res.status = ST_NOTHING;
                                n_done       = 1'b1;
                            end
                        end
                        default: begin
                            n_res        = '0;
                            n_res.status = ST_NOTHING;
                            n_done       = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                e_raddr = {r_src, r_i[IW-1:0]};
                if (r_dv) begin
                    if (flags.drop) begin
                        n_drop = 1'b1;
                    end
                    if (flags.take) begin
                        n_best = e_rdata;
                        n_have = 1'b1;
                    end
                end
                if (r_i < r_loaded) begin
                    n_i  = r_i + CW'(1);
                    n_dv = 1'b1;
                end else begin
                    n_dv = 1'b0;
                end
                if (!r_dv && r_i == r_loaded) begin
                    if (r_have) begin
                        e_we       = 1'b1;
                        e_waddr    = {~r_src, r_m[IW-1:0]};
                        e_wdata    = r_best;
                        n_m        = r_m + CW'(1);
                        n_prev_key = {r_best.row, r_best.column};
                        n_first    = 1'b0;
                        n_have     = 1'b0;
                        n_i        = '0;
                    end else begin
                        n_state = S_OFF_WAIT;
                        n_q     = '0;
                        n_oi    = '0;
                    end
                end
            end
            S_OFF_WAIT: begin
                e_raddr = {~r_src, r_q[IW-1:0]};
                n_state = S_OFF_CMP;
            end
            S_OFF_CMP: begin
                e_raddr = {~r_src, r_q[IW-1:0]};
                if (r_q < r_m && 32'(e_rdata.row) < 32'(r_oi)) begin
                    n_q     = r_q + CW'(1);
                    n_state = S_OFF_WAIT;
                end else begin
                    o_we = 1'b1;
                    if (r_oi == rows_now) begin
                        n_state      = S_IDLE;
                        n_src        = ~r_src;
                        n_lat_rows   = rows_now;
                        n_lat_slots  = slots_now;
                        n_rdptr      = '0;
                        n_phase      = PH_READING;
                        n_loaded     = r_m;
                        n_merged     = r_m;
                        n_res        = '0;
                        n_res.offset = FLD_W'(r_m);
                        if (r_m > slots_now) begin
                            n_res.status = ST_OVERFLOW;
                        end else if (r_drop) begin
                            n_res.status = ST_ROW_OOR;
                        end else begin
                            n_res.status = ST_OK;
                        end
                        n_done = 1'b1;
                    end else begin
                        n_oi = r_oi + RW'(1);
                    end
                end
            end
            S_RD_OUT: begin
                n_res = '0;
                if (p_le_r) begin
                    n_res.position = FLD_W'(r_rdptr);
                    n_res.offset   = FLD_W'(o_rdata);
                end else begin
                    n_res.kind     = 1'b1;
                    n_res.position = FLD_W'(e_full);
                    if (e_full < PW'(r_merged)) begin
                        n_res.column = e_rdata.column;
                        n_res.value  = e_rdata.value;
                    end
                end
                if (r_rdptr >= PW'(r_lat_rows) + PW'(r_lat_slots)) begin
                    n_res.last = 1'b1;
                    n_phase    = PH_DRAINED;
                end else begin
                    n_rdptr = r_rdptr + PW'(1);
                end
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_state == S_IDLE)
        else $error("result strobe outside idle");

    a_load_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_cmd.action == ACT_LOAD) |=> o_done)
        else $error("load gave no result");

    a_merged_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_m <= r_loaded)
        else $error("merged count exceeds loaded count");

    a_read_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RD_OUT |-> r_phase == PH_READING)
        else $error("readout outside reading phase");
`endif

endmodule
